// ===== rtl/ltota_pkg.sv =====
// Shared widths and types for the learned-task on-CPU time accounter.
`default_nettype none

package ltota_pkg;

    localparam int TASK_ID_W = 32;
    localparam int TIME_W    = 64;

    // Flags that the learned set reports for the item being retired.
    typedef struct packed {
        logic in_hit;    // the incoming ID is in the set after this item
        logic inserted;  // the outgoing ID was written into a slot
    } set_result_t;

endpackage

`default_nettype wire

// ===== rtl/learned_task_oncpu_time_accounter.sv =====
// Top level of the learned-task on-CPU time accounter.
`default_nettype none

// Each input item is one context switch. The outgoing task, when it belongs
// to the target, is looked up in a fully associative set of SET_CAPACITY
// learned task IDs and inserted on a miss in place of the least recently used
// slot; every hit, outgoing or incoming, and every insertion refreshes recency.
// For a target switch-out, time since a recorded (nonzero) slice start is
// charged to a wrapping 64-bit total. On every item the slice start is then
// set to the event time if the incoming ID is known, or cleared otherwise.
// The block takes one item per clock cycle sustained while the output side
// does not stall. An accepted item waits in the input register and moves into
// the output register once that register is empty or is being emptied; its
// result is then offered on the master side. The clock period is set by the
// parallel compare of all learned slots and the rank update of the LRU order,
// both done in the single pass between the two registers. The result register
// lets a new item enter while a finished result waits to be taken.
// After reset the set is empty and no slice is open; no clearing pass runs.
module learned_task_oncpu_time_accounter #(
    parameter int SET_CAPACITY = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // s_tdata, from bit 0: outgoing_task_id[31:0], incoming_task_id[31:0],
    // timestamp_ns[63:0].
    input  wire logic [2*ltota_pkg::TASK_ID_W+ltota_pkg::TIME_W-1:0] s_tdata,
    // s_tuser, from bit 0: outgoing_is_target.
    input  wire logic [0:0] s_tuser,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // m_tdata, from bit 0: total_oncpu_ns[63:0].
    output logic [ltota_pkg::TIME_W-1:0] m_tdata,
    // m_tuser, from bit 0: target_now_running, outgoing_newly_learned.
    output logic [1:0] m_tuser,
    output logic       m_tvalid,
    input  wire logic  m_tready
);
    import ltota_pkg::*;

    // Input register.
    logic                 stg_valid_reg;
    logic [TASK_ID_W-1:0] stg_out_id_reg;
    logic                 stg_target_reg;
    logic [TASK_ID_W-1:0] stg_in_id_reg;
    logic [TIME_W-1:0]    stg_ts_reg;

    // Result register.
    logic              out_valid_reg;
    logic [TIME_W-1:0] out_total_reg;
    logic              out_running_reg;
    logic              out_learned_reg;

    logic              advance;
    set_result_t       set_res;
    logic [TIME_W-1:0] total_cur;
    logic [TIME_W-1:0] total_next;

    // The staged item retires into the result register, and updates the
    // state, whenever that register is empty or is being emptied.
    assign advance  = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stg_valid_reg || advance;

    ltota_set #(
        .SET_CAPACITY(SET_CAPACITY)
    ) u_set (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (advance),
        .out_id       (stg_out_id_reg),
        .out_is_target(stg_target_reg),
        .in_id        (stg_in_id_reg),
        .result       (set_res)
    );

    ltota_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .charge      (stg_target_reg),
        .start_now   (set_res.in_hit),
        .timestamp_ns(stg_ts_reg),
        .total       (total_cur),
        .total_next  (total_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                stg_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            stg_out_id_reg <= s_tdata[TASK_ID_W-1:0];
            stg_in_id_reg  <= s_tdata[2*TASK_ID_W-1:TASK_ID_W];
            stg_ts_reg     <= s_tdata[2*TASK_ID_W+TIME_W-1:2*TASK_ID_W];
            stg_target_reg <= s_tuser[0];
        end
        if (advance) begin
            out_total_reg   <= total_next;
            out_running_reg <= set_res.in_hit;
            out_learned_reg <= set_res.inserted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_total_reg;
    assign m_tuser  = {out_learned_reg, out_running_reg};

`ifndef SYNTH
    // A waiting result is never overwritten by the staged item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result register overwritten while stalled");

    // Only a target switch-out can insert into the learned set.
    a_insert_target: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && set_res.inserted) |-> stg_target_reg)
        else $error("insertion for a non-target outgoing task");

    // A non-target switch-out never charges time.
    a_no_charge: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !stg_target_reg) |-> (total_next == total_cur))
        else $error("time charged for a non-target outgoing task");

    // The reported total is the one the accumulator holds after retiring.
    a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_total_reg == total_cur))
        else $error("reported total differs from the accumulator");
`endif

endmodule

`default_nettype wire

// ===== rtl/ltota_set.sv =====
// Fully associative learned task ID set with true LRU ranks per slot.
`default_nettype none

module ltota_set #(
    parameter int SET_CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           update,
    input  wire logic [ltota_pkg::TASK_ID_W-1:0] out_id,
    input  wire logic                           out_is_target,
    input  wire logic [ltota_pkg::TASK_ID_W-1:0] in_id,
    output ltota_pkg::set_result_t              result
);
    import ltota_pkg::*;

    localparam int RankW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    typedef logic [SET_CAPACITY-1:0][RankW-1:0]     rank_vec_t;
    typedef logic [SET_CAPACITY-1:0][TASK_ID_W-1:0] id_vec_t;

    // Each slot keeps its position in the recency order: 0 is the most recent.
    id_vec_t                 id_reg;
    logic [SET_CAPACITY-1:0] valid_reg;
    rank_vec_t               rank_reg;

    logic [SET_CAPACITY-1:0] out_hit;
    logic [SET_CAPACITY-1:0] victim;
    logic                    out_any;
    logic                    insert;
    logic [SET_CAPACITY-1:0] touch_out;
    id_vec_t                 id_mid;
    logic [SET_CAPACITY-1:0] valid_mid;
    rank_vec_t               rank_mid;
    logic [SET_CAPACITY-1:0] in_hit;
    rank_vec_t               rank_new;

    // Move the touched slot to the front; slots ahead of it slide back by one.
    function automatic rank_vec_t touch_ranks(input rank_vec_t r,
                                              input logic [SET_CAPACITY-1:0] t);
        rank_vec_t        res;
        logic [RankW-1:0] tr;
        logic             any;
        tr  = '0;
        any = |t;
        for (int s = 0; s < SET_CAPACITY; s++) begin
            if (t[s]) begin
                tr = tr | r[s];
            end
        end
        for (int s = 0; s < SET_CAPACITY; s++) begin
            if (!any) begin
                res[s] = r[s];
            end else if (t[s]) begin
                res[s] = '0;
            end else if (r[s] < tr) begin
                res[s] = r[s] + RankW'(1);
            end else begin
                res[s] = r[s];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        for (int s = 0; s < SET_CAPACITY; s++) begin
            out_hit[s] = valid_reg[s] && (id_reg[s] == out_id);
            victim[s]  = (rank_reg[s] == RankW'(SET_CAPACITY - 1));
        end
    end

    assign out_any   = |out_hit;
    assign insert    = out_is_target && !out_any;
    assign touch_out = out_is_target ? (out_any ? out_hit : victim) : '0;

    // The incoming lookup sees the set as the outgoing half left it.
    always_comb
    begin
        for (int s = 0; s < SET_CAPACITY; s++) begin
            id_mid[s]    = (insert && victim[s]) ? out_id : id_reg[s];
            valid_mid[s] = valid_reg[s] || (insert && victim[s]);
        end
    end

    assign rank_mid = touch_ranks(rank_reg, touch_out);

    always_comb
    begin
        for (int s = 0; s < SET_CAPACITY; s++) begin
            in_hit[s] = valid_mid[s] && (id_mid[s] == in_id);
        end
    end

    assign rank_new = touch_ranks(rank_mid, in_hit);

    assign result.in_hit   = |in_hit;
    assign result.inserted = insert;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            for (int s = 0; s < SET_CAPACITY; s++) begin
                rank_reg[s] <= RankW'(s);
            end
        end else if (update) begin
            valid_reg <= valid_mid;
            rank_reg  <= rank_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update) begin
            id_reg <= id_mid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ltota_acc.sv =====
// Slice start register and wrapping on-CPU time total.
`default_nettype none

module ltota_acc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        update,
    input  wire logic                        charge,
    input  wire logic                        start_now,
    input  wire logic [ltota_pkg::TIME_W-1:0] timestamp_ns,
    output logic      [ltota_pkg::TIME_W-1:0] total,
    output logic      [ltota_pkg::TIME_W-1:0] total_next
);
    import ltota_pkg::*;

    logic [TIME_W-1:0] slice_start_reg;
    logic [TIME_W-1:0] total_reg;

    // A zero slice start means no slice is open, so nothing is charged.
    assign total_next = (charge && (slice_start_reg != '0))
                      ? total_reg + (timestamp_ns - slice_start_reg)
                      : total_reg;
    assign total      = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slice_start_reg <= '0;
            total_reg       <= '0;
        end else if (update) begin
            slice_start_reg <= start_now ? timestamp_ns : '0;
            total_reg       <= total_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_learned_task_oncpu_time_accounter.sv =====
// Self-checking testbench for the learned-task on-CPU time accounter.
`default_nettype none

module tb_learned_task_oncpu_time_accounter;
    timeunit 1ns;
    timeprecision 1ps;

    import ltota_pkg::*;

    // The set size matches the block's default, so eviction is reached with
    // a modest pool of task IDs.
    localparam int SLOTS           = 64;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int RANDOM_SWITCHES = 1900;
    // Pool larger than the set so that target IDs keep pushing each other
    // out, with a hot subset that mostly stays learned and gives hits.
    localparam int ID_POOL         = 80;
    localparam int HOT_IDS         = 48;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;

    // One context-switch item as the sender sees it.
    typedef struct {
        logic [TASK_ID_W-1:0] out_id;
        logic                 out_target;
        logic [TASK_ID_W-1:0] in_id;
        logic [TIME_W-1:0]    stamp;
        bit                   drain_first;  // hold this item until all results are back
    } switch_t;

    // What the block reports after one switch.
    typedef struct {
        logic [TIME_W-1:0] total_ns;
        logic              running;
        logic              learned;
    } tally_t;

    logic clk    = 1'b0;
    logic rst_n  = 1'b0;

    // s_tdata, from bit 0: outgoing_task_id, incoming_task_id, timestamp_ns.
    logic [2*TASK_ID_W+TIME_W-1:0] s_tdata = '0;
    // s_tuser, from bit 0: outgoing_is_target.
    logic [0:0] s_tuser  = '0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    // m_tdata, from bit 0: total_oncpu_ns.
    logic [TIME_W-1:0] m_tdata;
    // m_tuser, from bit 0: target_now_running, outgoing_newly_learned.
    logic [1:0] m_tuser;
    logic       m_tvalid;
    logic       m_tready = 1'b0;

    learned_task_oncpu_time_accounter #(
        .SET_CAPACITY(SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: the learned set, its true-LRU order (position 0 is
    // the most recent slot), the open slice start and the running total.
    // ------------------------------------------------------------------
    logic [TASK_ID_W-1:0] learned_id  [SLOTS];
    bit                   learned_ok  [SLOTS];
    logic [SLOT_W-1:0]    recency     [SLOTS];
    logic [TIME_W-1:0]    slice_start_ns;
    logic [TIME_W-1:0]    oncpu_total_ns;

    switch_t pending_switches [$];
    tally_t  expected_tallies [$];
    logic [TASK_ID_W-1:0] id_pool [ID_POOL];

    switch_t on_bus;          // the item currently presented on the slave side
    tally_t  predicted;
    tally_t  oldest;
    int      accepted_count = 0;
    int      queued_count   = 0;
    int      results_seen   = 0;
    int      fail_count     = 0;
    int      cycle_count    = 0;
    int      src_gap        = 0;
    int      sink_hold      = 0;
    logic    calm_phase;

    // Every fourth stretch of 256 items runs with neither side idling.
    assign calm_phase = ((accepted_count / 256) % 4) == 1;

    // Slot holding id among the valid entries, or -1 on a miss.
    function automatic int slot_of(input logic [TASK_ID_W-1:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (learned_ok[s] && learned_id[s] == id)
                return s;
        return -1;
    endfunction

    // Move a slot to the front of the recency order.
    task automatic make_most_recent(input int slot);
        int pos;
        pos = 0;
        while (pos < SLOTS && recency[pos] != slot)
            pos++;
        for (int i = pos; i > 0; i--)
            recency[i] = recency[i - 1];
        recency[0] = SLOT_W'(slot);
    endtask

    // Apply one switch to the predictor state and return what the block
    // must report for it.
    task automatic account_switch(input switch_t sw, output tally_t res);
        int hit;
        int victim;
        res.learned = 1'b0;
        if (sw.out_target)
        begin
            hit = slot_of(sw.out_id);
            if (hit >= 0)
                make_most_recent(hit);
            else
            begin
                // The tail of the order is the victim; empty slots sit
                // there until they are filled.
                victim = recency[SLOTS - 1];
                learned_id[victim] = sw.out_id;
                learned_ok[victim] = 1'b1;
                make_most_recent(victim);
                res.learned = 1'b1;
            end
            // A zero start means no slice is open, so nothing is charged.
            if (slice_start_ns != '0)
                oncpu_total_ns += sw.stamp - slice_start_ns;
        end
        // The incoming lookup runs after the outgoing update, so a task
        // switched back in to itself hits the entry it just learned.
        slice_start_ns = '0;
        hit = slot_of(sw.in_id);
        res.running = (hit >= 0);
        if (res.running)
        begin
            make_most_recent(hit);
            slice_start_ns = sw.stamp;
        end
        res.total_ns = oncpu_total_ns;
    endtask

    task automatic add_switch(input logic [TASK_ID_W-1:0] out_id, input logic out_target,
                              input logic [TASK_ID_W-1:0] in_id, input logic [TIME_W-1:0] stamp,
                              input bit drain_first);
        switch_t sw;
        sw.out_id      = out_id;
        sw.out_target  = out_target;
        sw.in_id       = in_id;
        sw.stamp       = stamp;
        sw.drain_first = drain_first;
        pending_switches.push_back(sw);
        queued_count++;
    endtask

    // Task IDs mostly come from the pool, so lookups hit and evictions
    // happen; a few are fully random so every ID bit toggles.
    function automatic logic [TASK_ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return id_pool[$urandom_range(0, HOT_IDS - 1)];
        if (r < 92)
            return id_pool[$urandom_range(0, ID_POOL - 1)];
        return $urandom;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items on the slave side. On acceptance the
    // item is run through the predictor and its expected result queued.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                account_switch(on_bus, predicted);
                expected_tallies.push_back(predicted);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_switches.size() > 0 &&
                         !(pending_switches[0].drain_first && expected_tallies.size() != 0))
                begin
                    on_bus = pending_switches.pop_front();
                    s_tdata  <= {on_bus.stamp, on_bus.in_id, on_bus.out_id};
                    s_tuser  <= on_bus.out_target;
                    s_tvalid <= 1'b1;
                    src_gap  <= calm_phase ? 0 : idle_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stalls the master side at random and compares each result
    // taken with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_tallies.size() == 0)
                    note_failure($sformatf("result with nothing expected: total=%h flags=%b",
                                           m_tdata, m_tuser));
                else
                begin
                    oldest = expected_tallies.pop_front();
                    if (m_tdata !== oldest.total_ns || m_tuser[0] !== oldest.running ||
                        m_tuser[1] !== oldest.learned)
                        note_failure($sformatf(
                            "result %0d: expected total=%h running=%b learned=%b, got %h %b %b",
                            results_seen, oldest.total_ns, oldest.running, oldest.learned,
                            m_tdata, m_tuser[0], m_tuser[1]));
                    results_seen++;
                end
            end
            if (sink_hold > 0)
            begin
                m_tready  <= 1'b0;
                sink_hold <= sink_hold - 1;
            end
            else if (!calm_phase && $urandom_range(0, 3) == 0)
            begin
                m_tready  <= 1'b0;
                sink_hold <= idle_len();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        logic [TIME_W-1:0] clock_ns;
        int r;

        for (int s = 0; s < SLOTS; s++)
        begin
            learned_id[s] = '0;
            learned_ok[s] = 1'b0;
            recency[s]    = SLOT_W'(s);
        end
        slice_start_ns = '0;
        oncpu_total_ns = '0;
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = $urandom;

        // Directed part. An empty set must not match ID zero.
        add_switch(32'h1234_5678, 1'b0, 32'h0000_0000, 64'd0, 1'b0);
        // Target switched back in to itself: the fresh entry hits.
        add_switch(32'h0000_0000, 1'b1, 32'h0000_0000, 64'd5, 1'b0);
        // Charge a plain slice, then switch to an unknown task.
        add_switch(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 64'd100, 1'b0);
        // Learn the all-ones ID; the incoming task opens a slice at time zero.
        add_switch(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 64'd0, 1'b0);
        // The zero start reads as no slice, so nothing is charged.
        add_switch(32'h0000_0000, 1'b1, 32'h0000_0000, 64'd1000, 1'b0);
        // Non-target outgoing: no charge, but the start is rewritten.
        add_switch(32'h1234_5678, 1'b0, 32'hFFFF_FFFF, 64'd2000, 1'b0);
        // Time going backward wraps the difference.
        add_switch(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 64'd1500, 1'b0);
        // Largest timestamp.
        add_switch(32'h0000_0000, 1'b1, 32'h0000_0000, '1, 1'b0);
        add_switch(32'h0000_0000, 1'b1, 32'hAAAA_AAAA, 64'h8000_0000_0000_0000, 1'b0);
        add_switch(32'h5555_5555, 1'b1, 32'h5555_5555, 64'h5555_5555_5555_5555, 1'b0);
        add_switch(32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_switch(32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 64'hFFFF_FFFF_0000_0000, 1'b0);
        add_switch(32'hAAAA_AAAA, 1'b0, 32'h1234_5678, 64'h0000_0000_FFFF_FFFF, 1'b0);

        // Random part: mostly a monotonic clock with short slices, plus
        // backward steps, zero, near-wrap and fully random timestamps. The
        // first item and one halfway through wait for the block to drain.
        clock_ns = 64'd10_000;
        for (int n = 0; n < RANDOM_SWITCHES; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
                clock_ns += $urandom_range(1, 5000);
            else if (r < 92)
                clock_ns -= $urandom_range(1, 3000);
            else if (r < 95)
                clock_ns = {$urandom, $urandom};
            else if (r < 97)
                clock_ns = '0;
            else
                clock_ns = '1 - $urandom_range(0, 4000);
            add_switch(pick_id(), $urandom_range(0, 3) != 0, pick_id(), clock_ns,
                       n == 0 || n == RANDOM_SWITCHES / 2);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < queued_count)
            @(posedge clk);
        while (expected_tallies.size() != 0)
            @(posedge clk);
        // Any stray result shows up within this settling window.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_tallies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ltota_pkg.sv
rtl/ltota_set.sv
rtl/ltota_acc.sv
rtl/learned_task_oncpu_time_accounter.sv
bench/tb_learned_task_oncpu_time_accounter.sv
